[rtl/five_tuple_flow_table_macros.svh]
// Assertion macros for the five-tuple flow table.
// Expect clk and arst_n in the scope of use; no other dependencies.
`ifndef FIVE_TUPLE_FLOW_TABLE_MACROS_SVH
`define FIVE_TUPLE_FLOW_TABLE_MACROS_SVH

// Check a consequence in the same cycle.
`define FTFT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("five_tuple_flow_table: same-cycle check failed");

// Check a consequence in the next cycle.
`define FTFT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("five_tuple_flow_table: next-cycle check failed");

`endif

[rtl/ftft_pkg.sv]
// Shared types, codes and helpers of the five-tuple flow table.
// No dependencies; used by every module of the block.
package ftft_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int CIRCUIT_BITS_DEF  = 16;
	localparam int KEY_BITS          = 104;
	localparam int CIRCUIT_FIELD     = 16;
	localparam int COUNT_BITS        = 32;
	localparam int USED_FIELD        = 7;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;
	localparam logic [1:0] OP_DELETE = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [7:0]  proto_num;
		logic [15:0] new_circuit;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] found_circuit;
		logic [31:0] packet_count;
		logic [6:0]  entries_used;
	} out_word_t;

	typedef struct packed {
		logic valid_we;
		logic valid_bit;
		logic entry_we;
		logic pkt_we;
	} wr_ctl_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_ACT
	} ftft_state_t;

	function automatic int circ_width(input int bits);
		return (bits < CIRCUIT_FIELD) ? bits : CIRCUIT_FIELD;
	endfunction

	function automatic logic [KEY_BITS-1:0] make_key(input in_word_t w);
		return {w.source_ip, w.dest_ip, w.source_port, w.dest_port, w.proto_num};
	endfunction

endpackage

[rtl/ftft_store.sv]
// Slot storage of the flow table: valid map, keys, circuit ids, counters.
// One write port, one registered read port; depends on ftft_pkg.
module ftft_store #(
	parameter int TABLE_ENTRIES = ftft_pkg::TABLE_ENTRIES_DEF,
	parameter int CIRCUIT_BITS  = ftft_pkg::CIRCUIT_BITS_DEF
) (
	input  logic                                            clk,
	input  logic                                            rd_en,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]                rd_addr,
	input  ftft_pkg::wr_ctl_t                               wr,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]                wr_addr,
	input  logic [ftft_pkg::KEY_BITS-1:0]                   wr_key,
	input  logic [ftft_pkg::circ_width(CIRCUIT_BITS)-1:0]   wr_circuit,
	input  logic [ftft_pkg::COUNT_BITS-1:0]                 wr_packets,
	output logic                                            rd_valid,
	output logic [ftft_pkg::KEY_BITS-1:0]                   rd_key,
	output logic [ftft_pkg::circ_width(CIRCUIT_BITS)-1:0]   rd_circuit,
	output logic [ftft_pkg::COUNT_BITS-1:0]                 rd_packets
);
	import ftft_pkg::*;

	localparam int CIRC_W = circ_width(CIRCUIT_BITS);

	logic                  vld_mem [TABLE_ENTRIES];
	logic [KEY_BITS-1:0]   key_mem [TABLE_ENTRIES];
	logic [CIRC_W-1:0]     circ_mem [TABLE_ENTRIES];
	logic [COUNT_BITS-1:0] pkt_mem [TABLE_ENTRIES];

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [CIRC_W-1:0]     circ_q;
	logic [COUNT_BITS-1:0] pkt_q;

	always_ff @(posedge clk) begin
		if (wr.valid_we) begin
			vld_mem[wr_addr] <= wr.valid_bit;
		end
		if (wr.entry_we) begin
			key_mem[wr_addr]  <= wr_key;
			circ_mem[wr_addr] <= wr_circuit;
		end
		if (wr.pkt_we) begin
			pkt_mem[wr_addr] <= wr_packets;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			valid_q <= vld_mem[rd_addr];
			key_q   <= key_mem[rd_addr];
			circ_q  <= circ_mem[rd_addr];
			pkt_q   <= pkt_mem[rd_addr];
		end
	end

	assign rd_valid   = valid_q;
	assign rd_key     = key_q;
	assign rd_circuit = circ_q;
	assign rd_packets = pkt_q;

endmodule

[rtl/ftft_match.sv]
// Shared slot compare unit: free-slot test for insert, key match otherwise.
// Depends on ftft_pkg.
module ftft_match (
	input  logic                          insert_op,
	input  logic [ftft_pkg::KEY_BITS-1:0] req_key,
	input  logic [ftft_pkg::KEY_BITS-1:0] slot_key,
	input  logic                          slot_valid,
	output logic                          hit
);
	import ftft_pkg::*;

	logic key_eq;

	assign key_eq = (slot_key == req_key);
	assign hit    = insert_op ? !slot_valid : (slot_valid && key_eq);

endmodule

[rtl/ftft_ctrl.sv]
// Sequencer of the flow table: clearing pass, slot scan, write-back, result.
// Drives ftft_store and consumes ftft_match; depends on ftft_pkg.
module ftft_ctrl #(
	parameter int TABLE_ENTRIES = ftft_pkg::TABLE_ENTRIES_DEF,
	parameter int CIRCUIT_BITS  = ftft_pkg::CIRCUIT_BITS_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            req_valid,
	output logic                                            req_ready,
	input  ftft_pkg::in_word_t                              req,
	output logic                                            rsp_valid,
	input  logic                                            rsp_ready,
	output ftft_pkg::out_word_t                             rsp,
	output logic                                            rd_en,
	output logic [$clog2(TABLE_ENTRIES)-1:0]                rd_addr,
	output ftft_pkg::wr_ctl_t                               wr,
	output logic [$clog2(TABLE_ENTRIES)-1:0]                wr_addr,
	output logic [ftft_pkg::KEY_BITS-1:0]                   wr_key,
	output logic [ftft_pkg::circ_width(CIRCUIT_BITS)-1:0]   wr_circuit,
	output logic [ftft_pkg::COUNT_BITS-1:0]                 wr_packets,
	input  logic [ftft_pkg::circ_width(CIRCUIT_BITS)-1:0]   rd_circuit,
	input  logic [ftft_pkg::COUNT_BITS-1:0]                 rd_packets,
	input  logic                                            hit,
	output logic [ftft_pkg::KEY_BITS-1:0]                   req_key,
	output logic                                            insert_op
);
	import ftft_pkg::*;

	localparam int AW     = $clog2(TABLE_ENTRIES);
	localparam int CW     = $clog2(TABLE_ENTRIES + 1);
	localparam int CIRC_W = circ_width(CIRCUIT_BITS);
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0] LAST_CNT  = CW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0] END_CNT   = CW'(TABLE_ENTRIES);

	ftft_state_t           state_q, state_d;
	logic [CW-1:0]         scan_q;
	logic                  issued_s1;
	logic [AW-1:0]         addr_s1;
	logic [CW-1:0]         used_q;
	logic                  rsp_valid_q;

	in_word_t              req_q;
	logic                  found_q;
	logic [AW-1:0]         slot_q;
	logic [CIRC_W-1:0]     circ_q;
	logic [COUNT_BITS-1:0] pkt_q;
	out_word_t             rsp_q;

	logic                  scan_end;
	logic                  act_go;
	logic [COUNT_BITS-1:0] pkt_next;
	logic [CW-1:0]         used_next;
	logic [CIRC_W+15:0]    circ_ext;
	logic [CW+6:0]         used_ext;
	out_word_t             rsp_d;

	assign req_key   = make_key(req_q);
	assign insert_op = (req_q.opcode == OP_INSERT);
	assign scan_end  = issued_s1 && (hit || addr_s1 == LAST_SLOT);
	assign act_go    = (state_q == S_ACT) && (!rsp_valid_q || rsp_ready);
	assign pkt_next  = (pkt_q == COUNT_MAX) ? pkt_q : pkt_q + 32'd1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (scan_q == LAST_CNT) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					state_d = S_ACT;
				end
			end
			S_ACT: begin
				if (act_go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = scan_q[AW-1:0];
		wr         = '0;
		wr_addr    = slot_q;
		wr_key     = req_key;
		wr_circuit = req_q.new_circuit[CIRC_W-1:0];
		wr_packets = '0;
		case (state_q)
			S_CLEAR: begin
				wr.valid_we = 1'b1;
				wr.valid_bit = 1'b0;
				wr_addr = scan_q[AW-1:0];
			end
			S_IDLE: begin
				req_ready = 1'b1;
			end
			S_SCAN: begin
				rd_en = (scan_q != END_CNT) && !scan_end;
			end
			S_ACT: begin
				if (act_go && found_q) begin
					case (req_q.opcode)
						OP_INSERT: begin
							wr.valid_we = 1'b1;
							wr.valid_bit = 1'b1;
							wr.entry_we = 1'b1;
							wr.pkt_we = 1'b1;
						end
						OP_UPDATE: begin
							wr.pkt_we = 1'b1;
							wr_packets = pkt_next;
						end
						OP_DELETE: begin
							wr.valid_we = 1'b1;
							wr.valid_bit = 1'b0;
						end
						default: begin
							wr = '0;
						end
					endcase
				end
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_comb begin
		used_next = used_q;
		if (found_q && req_q.opcode == OP_INSERT) begin
			used_next = used_q + CW'(1);
		end else if (found_q && req_q.opcode == OP_DELETE && used_q != '0) begin
			used_next = used_q - CW'(1);
		end
		circ_ext = {16'd0, circ_q};
		used_ext = {7'd0, used_next};
		rsp_d.status = found_q ? ST_OK : (insert_op ? ST_FULL : ST_MISS);
		rsp_d.found_circuit = (found_q && req_q.opcode == OP_LOOKUP) ? circ_ext[15:0] : 16'd0;
		rsp_d.packet_count = (found_q && req_q.opcode == OP_UPDATE) ? pkt_next : 32'd0;
		rsp_d.entries_used = used_ext[6:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			scan_q      <= '0;
			issued_s1   <= 1'b0;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			issued_s1 <= rd_en;
			if (state_q == S_CLEAR) begin
				scan_q <= scan_q + CW'(1);
			end else if (state_q == S_IDLE) begin
				scan_q <= '0;
			end else if (rd_en) begin
				scan_q <= scan_q + CW'(1);
			end
			if (act_go) begin
				used_q      <= used_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == S_SCAN && scan_end) begin
			found_q <= hit;
			slot_q  <= addr_s1;
			circ_q  <= rd_circuit;
			pkt_q   <= rd_packets;
		end
		if (act_go) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/five_tuple_flow_table.sv]
// Top level of the five-tuple exact-match flow table.
// Instantiates ftft_ctrl, ftft_store and ftft_match; depends on ftft_pkg.
//
// channel   handshake              word
// req       req_valid/req_ready    ftft_pkg::in_word_t (opcode, flow key, new circuit)
// rsp       rsp_valid/rsp_ready    ftft_pkg::out_word_t (status, circuit, count, used)
//
// One slot is read and compared per cycle through the single read port of the slot
// store; the scan stops at the first hit or after the last slot, and the result is
// registered at write-back. req_ready rises in the same cycle as rsp_valid.
// After reset a clearing pass over every slot empties the valid map;
// req_ready stays low meanwhile. A stalled rsp holds the word; the next request is
// still taken and waits at write-back until the output register frees.
`include "five_tuple_flow_table_macros.svh"

module five_tuple_flow_table #(
	parameter int TABLE_ENTRIES = ftft_pkg::TABLE_ENTRIES_DEF,
	parameter int CIRCUIT_BITS  = ftft_pkg::CIRCUIT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ftft_pkg::in_word_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ftft_pkg::out_word_t rsp
);
	import ftft_pkg::*;

	localparam int AW     = $clog2(TABLE_ENTRIES);
	localparam int CIRC_W = circ_width(CIRCUIT_BITS);

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	wr_ctl_t               wr;
	logic [AW-1:0]         wr_addr;
	logic [KEY_BITS-1:0]   wr_key;
	logic [CIRC_W-1:0]     wr_circuit;
	logic [COUNT_BITS-1:0] wr_packets;
	logic                  rd_valid;
	logic [KEY_BITS-1:0]   rd_key;
	logic [CIRC_W-1:0]     rd_circuit;
	logic [COUNT_BITS-1:0] rd_packets;
	logic                  hit;
	logic [KEY_BITS-1:0]   req_key;
	logic                  insert_op;

	ftft_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.CIRCUIT_BITS (CIRCUIT_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.wr        (wr),
		.wr_addr   (wr_addr),
		.wr_key    (wr_key),
		.wr_circuit(wr_circuit),
		.wr_packets(wr_packets),
		.rd_circuit(rd_circuit),
		.rd_packets(rd_packets),
		.hit       (hit),
		.req_key   (req_key),
		.insert_op (insert_op)
	);

	ftft_store #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.CIRCUIT_BITS (CIRCUIT_BITS)
	) u_store (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.wr        (wr),
		.wr_addr   (wr_addr),
		.wr_key    (wr_key),
		.wr_circuit(wr_circuit),
		.wr_packets(wr_packets),
		.rd_valid  (rd_valid),
		.rd_key    (rd_key),
		.rd_circuit(rd_circuit),
		.rd_packets(rd_packets)
	);

	ftft_match u_match (
		.insert_op (insert_op),
		.req_key   (req_key),
		.slot_key  (rd_key),
		.slot_valid(rd_valid),
		.hit       (hit)
	);

	`FTFT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
	`FTFT_ASSERT_SAME(a_status_code, rsp_valid, rsp.status == ST_OK || rsp.status == ST_MISS || rsp.status == ST_FULL)
	`FTFT_ASSERT_SAME(a_fail_fields_zero, rsp_valid && rsp.status != ST_OK, rsp.found_circuit == 16'd0 && rsp.packet_count == 32'd0)

endmodule

[sim/five_tuple_flow_table_tb.sv]
// Self-checking testbench of the five-tuple flow table: directed and random
// insert, lookup, update and delete words against an in-bench table predictor.
// Depends on ftft_pkg and five_tuple_flow_table.
`timescale 1ns / 1ps

module five_tuple_flow_table_tb;

	import ftft_pkg::*;

	localparam int SLOTS     = TABLE_ENTRIES_DEF;
	localparam int CIRC_BITS = CIRCUIT_BITS_DEF;
	localparam logic [15:0] CIRC_MASK = 16'((32'd1 << CIRC_BITS) - 1);
	localparam int POOL_KEYS = 42;
	localparam int LONG_HOLD = 600;

	typedef struct {
		in_word_t    w;
		int unsigned gap;
		bit          wait_idle;
	} queued_req_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	in_word_t  req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	out_word_t rsp;

	queued_req_t pending_words[$];
	out_word_t   flow_results[$];
	in_word_t    key_pool[POOL_KEYS];

	bit           slot_live[SLOTS];
	logic [103:0] slot_key[SLOTS];
	logic [15:0]  slot_circ[SLOTS];
	logic [31:0]  slot_pkts[SLOTS];
	int unsigned  live_count;

	bit          offered;
	int unsigned waited;
	int unsigned stall_left;
	int unsigned results_seen;
	int unsigned mismatch_count;

	five_tuple_flow_table #(
		.TABLE_ENTRIES(SLOTS),
		.CIRCUIT_BITS(CIRC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	task automatic note_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] flow table: %s", $realtime, what);
	endtask

	function automatic void advance_flow_table(input in_word_t w);
		out_word_t    r;
		logic [103:0] k;
		int           hit;
		r = '0;
		k = {w.source_ip, w.dest_ip, w.source_port, w.dest_port, w.proto_num};
		hit = -1;
		if (w.opcode == OP_INSERT) begin
			r.status = ST_FULL;
			for (int i = 0; i < SLOTS; i++) begin
				if (!slot_live[i]) begin
					slot_live[i] = 1'b1;
					slot_key[i] = k;
					slot_circ[i] = w.new_circuit & CIRC_MASK;
					slot_pkts[i] = '0;
					live_count++;
					r.status = ST_OK;
					break;
				end
			end
		end else begin
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_live[i] && slot_key[i] == k) begin
					hit = i;
					break;
				end
			end
			if (hit < 0) begin
				r.status = ST_MISS;
			end else if (w.opcode == OP_LOOKUP) begin
				r.found_circuit = slot_circ[hit];
			end else if (w.opcode == OP_UPDATE) begin
				if (slot_pkts[hit] != COUNT_MAX)
					slot_pkts[hit] = slot_pkts[hit] + 1;
				r.packet_count = slot_pkts[hit];
			end else begin
				slot_live[hit] = 1'b0;
				if (live_count > 0)
					live_count--;
			end
		end
		r.entries_used = live_count[6:0];
		flow_results.push_back(r);
	endfunction

	task automatic check_result(input out_word_t got);
		out_word_t want;
		if (flow_results.size() == 0) begin
			note_mismatch($sformatf("word %h with nothing pending", got));
			return;
		end
		want = flow_results.pop_front();
		if (got.status !== want.status)
			note_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
		if (got.found_circuit !== want.found_circuit)
			note_mismatch($sformatf("circuit %h, want %h", got.found_circuit,
				want.found_circuit));
		if (got.packet_count !== want.packet_count)
			note_mismatch($sformatf("count %h, want %h", got.packet_count,
				want.packet_count));
		if (got.entries_used !== want.entries_used)
			note_mismatch($sformatf("used %0d, want %0d", got.entries_used,
				want.entries_used));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			offered = 1'b0;
			waited = 0;
		end else begin
			if (req_valid && req_ready) begin
				advance_flow_table(req);
				offered = 1'b0;
				waited = 0;
			end
			if (!offered && pending_words.size() > 0) begin
				if (waited < pending_words[0].gap) begin
					waited++;
				end else if (!(pending_words[0].wait_idle && flow_results.size() != 0)) begin
					req <= pending_words[0].w;
					void'(pending_words.pop_front());
					offered = 1'b1;
				end
			end
			req_valid <= offered;
		end
	end

	function automatic int unsigned pick_stall();
		int unsigned r;
		r = $urandom_range(0, 99);
		if ((results_seen / 150) % 4 == 2)
			return 0;
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(15, 60);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left = 0;
			results_seen = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				check_result(rsp);
				results_seen++;
				stall_left = (results_seen == 400) ? LONG_HOLD : pick_stall();
			end else if (stall_left > 0) begin
				stall_left--;
			end
			rsp_ready <= (stall_left == 0);
		end
	end

	function automatic int unsigned pick_gap(input bit no_idle);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic in_word_t near_miss(input in_word_t w);
		logic [103:0] k;
		k = {w.source_ip, w.dest_ip, w.source_port, w.dest_port, w.proto_num};
		k ^= 104'd1 << $urandom_range(0, 103);
		{w.source_ip, w.dest_ip, w.source_port, w.dest_port, w.proto_num} = k;
		return w;
	endfunction

	function automatic in_word_t random_key();
		in_word_t w;
		w.opcode = OP_LOOKUP;
		w.source_ip = $urandom;
		w.dest_ip = $urandom;
		w.source_port = 16'($urandom_range(0, 65535));
		w.dest_port = 16'($urandom_range(0, 65535));
		w.proto_num = 8'($urandom_range(0, 255));
		w.new_circuit = 16'($urandom_range(0, 65535));
		return w;
	endfunction

	task automatic queue_op(input logic [1:0] op, input in_word_t key, input logic [15:0] circ,
			input bit no_idle, input bit wait_idle);
		queued_req_t q;
		q.w = key;
		q.w.opcode = op;
		q.w.new_circuit = circ;
		q.gap = pick_gap(no_idle);
		q.wait_idle = wait_idle;
		pending_words.push_back(q);
	endtask

	task automatic queue_segment(input int seg, input int ins_pct, input int del_pct);
		logic [1:0]  op;
		in_word_t    key;
		int unsigned r;
		for (int n = 0; n < 100; n++) begin
			r = $urandom_range(0, 99);
			if (r < ins_pct)
				op = OP_INSERT;
			else if (r < ins_pct + del_pct)
				op = OP_DELETE;
			else if ($urandom_range(0, 1))
				op = OP_LOOKUP;
			else
				op = OP_UPDATE;
			key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
			r = $urandom_range(0, 99);
			if (op != OP_INSERT && r < 10)
				key = near_miss(key);
			else if (op != OP_INSERT && r < 20)
				key = random_key();
			queue_op(op, key, 16'($urandom_range(0, 65535)), seg % 4 == 3,
				n == 0 && (seg == 5 || seg == 12));
		end
	endtask

	initial begin
		in_word_t zero_key;
		in_word_t ones_key;
		int       kind;
		mismatch_count = 0;
		live_count = 0;
		for (int i = 0; i < SLOTS; i++)
			slot_live[i] = 1'b0;
		for (int i = 0; i < POOL_KEYS; i++)
			key_pool[i] = random_key();
		key_pool[0] = '0;
		key_pool[1] = '1;
		zero_key = key_pool[0];
		ones_key = key_pool[1];

		queue_op(OP_INSERT, zero_key, 16'h0000, 1'b0, 1'b0);
		queue_op(OP_INSERT, ones_key, 16'hFFFF, 1'b0, 1'b0);
		queue_op(OP_LOOKUP, zero_key, 16'hFFFF, 1'b0, 1'b0);
		queue_op(OP_LOOKUP, ones_key, 16'h0000, 1'b0, 1'b0);
		queue_op(OP_UPDATE, ones_key, 16'h0000, 1'b0, 1'b0);
		queue_op(OP_UPDATE, ones_key, 16'h0000, 1'b0, 1'b0);
		queue_op(OP_UPDATE, zero_key, 16'h0000, 1'b0, 1'b0);
		queue_op(OP_INSERT, zero_key, 16'h1234, 1'b0, 1'b0);
		queue_op(OP_LOOKUP, zero_key, 16'h0000, 1'b0, 1'b0);
		queue_op(OP_DELETE, zero_key, 16'h0000, 1'b0, 1'b0);
		queue_op(OP_LOOKUP, zero_key, 16'h0000, 1'b0, 1'b0);
		queue_op(OP_UPDATE, zero_key, 16'h0000, 1'b0, 1'b0);
		queue_op(OP_INSERT, key_pool[2], 16'hABCD, 1'b0, 1'b0);
		queue_op(OP_LOOKUP, near_miss(ones_key), 16'h0000, 1'b0, 1'b0);
		queue_op(OP_UPDATE, random_key(), 16'h0000, 1'b0, 1'b0);
		queue_op(OP_DELETE, random_key(), 16'h0000, 1'b0, 1'b0);
		queue_op(OP_DELETE, ones_key, 16'h0000, 1'b0, 1'b0);
		queue_op(OP_DELETE, zero_key, 16'h0000, 1'b0, 1'b0);
		queue_op(OP_DELETE, zero_key, 16'h0000, 1'b0, 1'b0);
		queue_op(OP_DELETE, key_pool[2], 16'h0000, 1'b0, 1'b0);
		queue_op(OP_LOOKUP, key_pool[2], 16'h0000, 1'b0, 1'b0);

		for (int seg = 0; seg < 19; seg++) begin
			kind = (seg == 0 || seg == 9) ? 0 : (seg == 1 || seg == 10) ? 1 :
				$urandom_range(0, 3);
			case (kind)
				0: queue_segment(seg, 85, 5);
				1: queue_segment(seg, 10, 60);
				default: queue_segment(seg, 25, 20);
			endcase
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_words.size() != 0 || offered)
			@(posedge clk);
		while (flow_results.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#8ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
